@@ hw/rtl/pof_pkg.sv @@
// Shared types and constants of the pattern offset finder.
package pof_pkg;

    // Default window size: the largest pattern length the window supports unless overridden.
    localparam int MAX_PATTERN_BYTES_DEF = 8;

    localparam int PATTERN_W      = 64;
    localparam int LENGTH_W       = 4;
    localparam int COUNT_W        = 8;
    localparam int LIMIT_W        = 16;
    localparam int POS_W          = 17;
    localparam int CFG_INDEX_W    = 2;

    localparam logic [POS_W-1:0]     POS_MAX          = '1;
    localparam logic [COUNT_W-1:0]   COUNT_MAX        = '1;
    localparam logic [LENGTH_W-1:0]  LENGTH_RESET     = 4'd8;
    localparam logic [COUNT_W-1:0]   MAX_MATCH_RESET  = 8'd1;
    localparam logic [LIMIT_W-1:0]   LIMIT_RESET      = 16'd1024;

    // Configuration register indexes.
    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_PATTERN      = 2'd0,
        REG_LENGTH       = 2'd1,
        REG_MAX_MATCHES  = 2'd2,
        REG_SEARCH_LIMIT = 2'd3
    } t_cfg_reg;

    typedef struct packed {
        logic [PATTERN_W-1:0] pattern;
        logic [LENGTH_W-1:0]  pattern_length;
        logic [COUNT_W-1:0]   max_matches;
        logic [LIMIT_W-1:0]   search_limit;
    } t_cfg;

endpackage

@@ hw/rtl/pof_in_if.sv @@
// Byte stream channel into the pattern offset finder.
interface pof_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] code_byte;
    logic       first_byte;

    modport source (output valid, output code_byte, output first_byte, input ready);
    modport sink   (input valid, input code_byte, input first_byte, output ready);
endinterface

@@ hw/rtl/pof_out_if.sv @@
// Match result channel out of the pattern offset finder.
interface pof_out_if;
    logic        valid;
    logic        ready;
    logic [15:0] match_offset;
    logic [7:0]  match_number;
    logic        search_done;

    modport source (output valid, output match_offset, output match_number,
                    output search_done, input ready);
    modport sink   (input valid, input match_offset, input match_number,
                    input search_done, output ready);
endinterface

@@ hw/rtl/pof_cfg_regs.sv @@
// Configuration register file of the pattern offset finder.
module pof_cfg_regs (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_cfg_we,
    input  logic [pof_pkg::CFG_INDEX_W-1:0]      i_cfg_index,
    input  logic [pof_pkg::PATTERN_W-1:0]        i_cfg_data,
    output pof_pkg::t_cfg                        o_cfg
);

    pof_pkg::t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.pattern        <= '0;
            r_cfg.pattern_length <= pof_pkg::LENGTH_RESET;
            r_cfg.max_matches    <= pof_pkg::MAX_MATCH_RESET;
            r_cfg.search_limit   <= pof_pkg::LIMIT_RESET;
        end else if (i_cfg_we) begin
            case (pof_pkg::t_cfg_reg'(i_cfg_index))
                pof_pkg::REG_PATTERN: begin
                    r_cfg.pattern <= i_cfg_data;
                end
                pof_pkg::REG_LENGTH: begin
                    r_cfg.pattern_length <= i_cfg_data[pof_pkg::LENGTH_W-1:0];
                end
                pof_pkg::REG_MAX_MATCHES: begin
                    r_cfg.max_matches <= i_cfg_data[pof_pkg::COUNT_W-1:0];
                end
                pof_pkg::REG_SEARCH_LIMIT: begin
                    r_cfg.search_limit <= i_cfg_data[pof_pkg::LIMIT_W-1:0];
                end
                default: begin
                    r_cfg <= r_cfg;
                end
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

@@ hw/rtl/pof_window_cmp.sv @@
// Parallel compare of the newest window bytes against the pattern.
module pof_window_cmp #(
    parameter int MAX_PATTERN_BYTES = pof_pkg::MAX_PATTERN_BYTES_DEF
) (
    input  logic [8*MAX_PATTERN_BYTES-1:0]    i_window,
    input  logic [pof_pkg::PATTERN_W-1:0]     i_pattern,
    input  logic [pof_pkg::LENGTH_W-1:0]      i_len,
    output logic                              o_hit
);

    logic [MAX_PATTERN_BYTES:1] w_match;

    // For each length, the newest bytes sit in the top lanes with pattern
    // byte zero in the lowest of them.
    for (genvar gl = 1; gl <= MAX_PATTERN_BYTES; gl++) begin : g_len
        assign w_match[gl] = (i_window[8*MAX_PATTERN_BYTES-1 -: 8*gl]
                              == i_pattern[8*gl-1:0]);
    end

    always_comb begin
        o_hit = 1'b0;
        for (int l = 1; l <= MAX_PATTERN_BYTES; l++) begin
            if (i_len == pof_pkg::LENGTH_W'(l)) begin
                o_hit = w_match[l];
            end
        end
    end

endmodule

@@ hw/rtl/pattern_offset_finder_core.sv @@
// Top level of the pattern offset finder: stream search for a byte pattern.
//
// The block takes one byte item per cycle and reports where a configured
// pattern of one to MAX_PATTERN_BYTES bytes starts in the byte stream. Each
// item passes an input register, then logic that shifts the byte into a
// window, compares every pattern length in parallel and updates the search
// state, and then a result register, which holds the result of a matching
// item for the result channel. The window compare and the state update are
// both combinational, which lets a new item enter on every clock unless the
// input is held; the result register decouples the two channels, so the
// byte stream keeps flowing while a result waits, and only a second match
// arriving behind an untaken result holds the input.
// A result is produced only for a match that starts below the search limit
// and at or after the end of the previous match plus one byte. When the
// configured match count is reached (or 255 matches, whatever the count),
// that result carries the done flag and the block ignores the rest of the
// region. A first-byte item starts a new region at offset zero. The user
// must write configuration registers only while the block is idle, which
// it does not enforce; a write applies from the next item and never restarts the search.
module pattern_offset_finder_core #(
    parameter int MAX_PATTERN_BYTES = pof_pkg::MAX_PATTERN_BYTES_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [pof_pkg::CFG_INDEX_W-1:0]    i_cfg_index,
    input  logic [pof_pkg::PATTERN_W-1:0]      i_cfg_data,
    pof_in_if.sink                             i_byte_if,
    pof_out_if.source                          o_match_if
);

    localparam int WinW = 8 * MAX_PATTERN_BYTES;
    localparam int PosW = pof_pkg::POS_W;

    pof_pkg::t_cfg w_cfg;

    pof_cfg_regs u_cfg_regs (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (w_cfg)
    );

    // Input register.
    logic       r_in_valid;
    logic [7:0] r_in_byte;
    logic       r_in_first;

    // Search state.
    logic [WinW-1:0]              r_window;
    logic [PosW-1:0]              r_pos;
    logic [pof_pkg::COUNT_W-1:0]  r_found;
    logic [PosW-1:0]              r_next_start;
    logic                         r_stopped;

    // Result register.
    logic                         r_out_valid;
    logic [pof_pkg::LIMIT_W-1:0]  r_out_offset;
    logic [pof_pkg::COUNT_W-1:0]  r_out_number;
    logic                         r_out_done;

    // A first-byte item sees the state as if the region had just begun.
    logic [WinW-1:0]              w_win_base;
    logic [PosW-1:0]              w_pos_base;
    logic [pof_pkg::COUNT_W-1:0]  w_found_base;
    logic [PosW-1:0]              w_next_base;
    logic                         w_stopped_base;

    assign w_win_base     = r_in_first ? '0 : r_window;
    assign w_pos_base     = r_in_first ? '0 : r_pos;
    assign w_found_base   = r_in_first ? '0 : r_found;
    assign w_next_base    = r_in_first ? '0 : r_next_start;
    assign w_stopped_base = r_in_first ? 1'b0 : r_stopped;

    // The newest byte enters the top lane.
    logic [WinW-1:0] n_window;
    if (MAX_PATTERN_BYTES == 1) begin : g_win_one
        assign n_window = r_in_byte;
    end else begin : g_win_many
        assign n_window = {r_in_byte, w_win_base[WinW-1:8]};
    end

    // Effective pattern length: zero counts as one, and it is capped at the
    // window size.
    logic [pof_pkg::LENGTH_W-1:0] w_len;
    always_comb begin
        w_len = w_cfg.pattern_length;
        if (w_len == '0) begin
            w_len = pof_pkg::LENGTH_W'(1);
        end
        if (w_len > pof_pkg::LENGTH_W'(MAX_PATTERN_BYTES)) begin
            w_len = pof_pkg::LENGTH_W'(MAX_PATTERN_BYTES);
        end
    end

    logic w_cmp_hit;

    pof_window_cmp #(
        .MAX_PATTERN_BYTES (MAX_PATTERN_BYTES)
    ) u_window_cmp (
        .i_window  (n_window),
        .i_pattern (w_cfg.pattern),
        .i_len     (w_len),
        .o_hit     (w_cmp_hit)
    );

    // Start offset of the candidate that ends at this byte.
    logic [PosW:0]                w_pos_p1;
    logic [PosW:0]                w_start_full;
    logic [PosW-1:0]              w_start;
    logic                         w_len_ok;
    logic                         w_in_range;
    logic                         w_hit;
    logic [pof_pkg::COUNT_W-1:0]  w_count;
    logic                         w_done;
    logic [PosW:0]                w_next_full;
    logic [PosW-1:0]              n_pos;

    assign w_pos_p1     = {1'b0, w_pos_base} + (PosW+1)'(1);
    assign w_len_ok     = w_pos_p1 >= (PosW+1)'(w_len);
    assign w_start_full = w_pos_p1 - (PosW+1)'(w_len);
    assign w_start      = w_start_full[PosW-1:0];
    assign w_in_range   = (w_start < PosW'(w_cfg.search_limit))
                          && (w_start >= w_next_base);
    assign w_hit        = !w_stopped_base && w_len_ok && w_in_range && w_cmp_hit;
    assign w_count      = w_found_base + pof_pkg::COUNT_W'(1);
    assign w_done       = (w_count == w_cfg.max_matches)
                          || (w_count == pof_pkg::COUNT_MAX);
    assign w_next_full  = {1'b0, w_start} + (PosW+1)'(w_len) + (PosW+1)'(1);
    assign n_pos        = (w_pos_base == pof_pkg::POS_MAX) ? w_pos_base
                                                           : w_pos_p1[PosW-1:0];

    // Handshake: an item without a match moves on even when the result
    // register is full; a matching item waits for room there.
    logic w_out_free;
    logic w_adv;
    logic w_emit;
    logic w_in_ready;

    assign w_out_free = !r_out_valid || o_match_if.ready;
    assign w_adv      = r_in_valid && (w_out_free || !w_hit);
    assign w_emit     = w_adv && w_hit;
    assign w_in_ready = !r_in_valid || w_adv;

    assign i_byte_if.ready = w_in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid   <= 1'b0;
            r_in_byte    <= '0;
            r_in_first   <= 1'b0;
            r_window     <= '0;
            r_pos        <= '0;
            r_found      <= '0;
            r_next_start <= '0;
            r_stopped    <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            if (w_in_ready) begin
                r_in_valid <= i_byte_if.valid;
                if (i_byte_if.valid) begin
                    r_in_byte  <= i_byte_if.code_byte;
                    r_in_first <= i_byte_if.first_byte;
                end
            end
            if (w_adv) begin
                r_window     <= n_window;
                r_pos        <= n_pos;
                r_found      <= w_hit ? w_count : w_found_base;
                r_next_start <= w_hit ? w_next_full[PosW-1:0] : w_next_base;
                r_stopped    <= w_stopped_base || (w_hit && w_done);
            end
            if (w_out_free) begin
                r_out_valid <= w_emit;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_free && w_emit) begin
            r_out_offset <= w_start[pof_pkg::LIMIT_W-1:0];
            r_out_number <= w_count;
            r_out_done   <= w_done;
        end
    end

    assign o_match_if.valid        = r_out_valid;
    assign o_match_if.match_offset = r_out_offset;
    assign o_match_if.match_number = r_out_number;
    assign o_match_if.search_done  = r_out_done;

    // A result never overwrites one that has not been taken.
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_emit |-> w_out_free)
        else $error("result register overwritten");

    // Once stopped, a region yields no match until a new region begins.
    a_stopped_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !r_in_first && r_stopped) |-> !w_hit)
        else $error("match reported after the search stopped");

    // A result carrying the done flag leaves the search stopped.
    a_done_stops: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_emit && w_done) |=> r_stopped)
        else $error("search not stopped after final match");

    // A reported match number counts from one.
    a_number_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out_number != '0))
        else $error("match number zero on a result");

    // The next allowed start always lies past the start of the last reported match.
    a_next_after: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_emit |=> (r_next_start > $past(w_start)))
        else $error("next allowed start not past the match");

endmodule

@@ bench/pof_match_sb_pkg.sv @@
// Scoreboard class for the pattern offset finder: match predictor and result checker.
`timescale 1ns / 100ps
package pof_match_sb_pkg;
    import pof_pkg::*;

    localparam int MISMATCH_REPORTS = 10;

    typedef struct packed {
        logic [LIMIT_W-1:0] offset;
        logic [COUNT_W-1:0] number;
        logic               done;
    } t_match;

    class pof_match_scoreboard;
        t_cfg               cfg;
        logic [63:0]        window;
        logic [POS_W-1:0]   position;
        logic [COUNT_W-1:0] found;
        logic [POS_W-1:0]   next_start;
        bit                 stopped;
        t_match             pending_matches[$];
        int                 mismatch_count;

        function new();
            cfg.pattern        = '0;
            cfg.pattern_length = LENGTH_RESET;
            cfg.max_matches    = MAX_MATCH_RESET;
            cfg.search_limit   = LIMIT_RESET;
            mismatch_count     = 0;
            restart_region();
        endfunction

        function void restart_region();
            window     = '0;
            position   = '0;
            found      = '0;
            next_start = '0;
            stopped    = 1'b0;
        endfunction

        function void write_reg(t_cfg_reg idx, logic [PATTERN_W-1:0] value);
            case (idx)
                REG_PATTERN:      cfg.pattern        = value;
                REG_LENGTH:       cfg.pattern_length = value[LENGTH_W-1:0];
                REG_MAX_MATCHES:  cfg.max_matches    = value[COUNT_W-1:0];
                REG_SEARCH_LIMIT: cfg.search_limit   = value[LIMIT_W-1:0];
                default: ;
            endcase
        endfunction

        // Zero counts as one byte, anything past the window as the full window.
        function int unsigned active_length();
            int unsigned n;
            n = cfg.pattern_length;
            if (n == 0) n = 1;
            if (n > MAX_PATTERN_BYTES_DEF) n = MAX_PATTERN_BYTES_DEF;
            return n;
        endfunction

        function void note_byte(logic [7:0] code, logic first);
            int unsigned pos;
            int unsigned len;
            int unsigned start;
            logic [63:0] mask;
            logic [63:0] seen;
            t_match      m;
            if (first) restart_region();
            pos    = position;
            window = {code, window[63:8]};
            if (position != POS_MAX) position = position + 1'b1;
            if (stopped) return;
            len = active_length();
            if (pos + 1 < len) return;
            start = pos + 1 - len;
            if (start >= cfg.search_limit || start < next_start) return;
            mask = (len >= 8) ? '1 : ((64'd1 << (8 * len)) - 64'd1);
            seen = (window >> (8 * (8 - len))) & mask;
            if (seen != (cfg.pattern & mask)) return;
            found      = found + 1'b1;
            next_start = POS_W'(start + len + 1);
            m.offset   = LIMIT_W'(start);
            m.number   = found;
            m.done     = (found == cfg.max_matches) || (found == COUNT_MAX);
            if (m.done) stopped = 1'b1;
            pending_matches.push_back(m);
        endfunction

        function void report_mismatch(string msg);
            mismatch_count++;
            if (mismatch_count <= MISMATCH_REPORTS) $display("%0t: %s", $time, msg);
        endfunction

        function void check_match(t_match got);
            t_match expected;
            if (pending_matches.size() == 0) begin
                report_mismatch($sformatf("unexpected match: offset %0d number %0d done %0b",
                                          got.offset, got.number, got.done));
                return;
            end
            expected = pending_matches.pop_front();
            if (got.offset !== expected.offset || got.number !== expected.number ||
                got.done !== expected.done) begin
                report_mismatch($sformatf(
                    "match mismatch: expected offset %0d number %0d done %0b, got %0d %0d %0b",
                    expected.offset, expected.number, expected.done,
                    got.offset, got.number, got.done));
            end
        endfunction
    endclass

endpackage

@@ bench/tb_pattern_offset_finder_core.sv @@
// Testbench of the pattern offset finder core: directed and random byte streams.
`timescale 1ns / 100ps
module tb_pattern_offset_finder_core;
    import pof_pkg::*;
    import pof_match_sb_pkg::*;

    // Extra clock edges that settling waits once the last predicted match is out.
    localparam int SETTLE_CYCLES     = 4;
    localparam int WATCHDOG_LIMIT    = 2000;
    localparam int RANDOM_PHASES     = 5;
    localparam int SATURATION_BYTES  = 512;
    localparam int IDLE_PERCENT      = 36;

    logic                   i_clk;
    logic                   i_rst_n;
    logic                   i_cfg_we;
    logic [CFG_INDEX_W-1:0] i_cfg_index;
    logic [PATTERN_W-1:0]   i_cfg_data;
    bit                     idle_enable;

    pof_in_if  byte_ch();
    pof_out_if match_ch();

    pof_match_scoreboard match_model;

    pattern_offset_finder_core dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_byte_if   (byte_ch),
        .o_match_if  (match_ch)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // The result side stalls at random while idling is enabled, and never otherwise.
    initial begin
        match_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            match_ch.ready <= !idle_enable || ($urandom_range(99) >= IDLE_PERCENT);
        end
    end

    // Both channels are sampled at the clock edge, before the block's own
    // registers update, so the accepted item and result are the ones that
    // the block saw at that edge. Inputs are noted before results are
    // checked; as an item passes the input register and the result register,
    // no result can depend on an item accepted at the same edge anyway.
    always @(posedge i_clk) begin
        if (i_rst_n && byte_ch.valid && byte_ch.ready) begin
            match_model.note_byte(byte_ch.code_byte, byte_ch.first_byte);
        end
        if (i_rst_n && match_ch.valid && match_ch.ready) begin
            match_model.check_match('{offset: match_ch.match_offset,
                                      number: match_ch.match_number,
                                      done:   match_ch.search_done});
        end
    end

    // The run is cut short when nothing moves on any port for too long.
    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if ((byte_ch.valid && byte_ch.ready) || (match_ch.valid && match_ch.ready) ||
                i_cfg_we || !i_rst_n) begin
                quiet = 0;
            end else begin
                quiet++;
            end
        end
        $display("CHECKS FAILED");
        $finish;
    end

    // Offers one byte item, after random idle cycles when idling is enabled, and
    // returns at the edge where it is taken. Valid stays high on return, so
    // the next call either replaces the item or lowers valid for a gap.
    task automatic send_byte(input logic [7:0] code, input logic first);
        while (idle_enable && $urandom_range(99) < IDLE_PERCENT) begin
            byte_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        byte_ch.valid      <= 1'b1;
        byte_ch.code_byte  <= code;
        byte_ch.first_byte <= first;
        @(posedge i_clk);
        while (byte_ch.ready !== 1'b1) @(posedge i_clk);
    endtask

    // Stops the byte stream and waits until every predicted match has come
    // out. An item that matches nothing may still be inside the block, so a
    // few more cycles pass before the block counts as idle.
    task automatic settle();
        byte_ch.valid <= 1'b0;
        while (match_model.pending_matches.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input t_cfg_reg idx, input logic [PATTERN_W-1:0] value);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        @(posedge i_clk);
        match_model.write_reg(idx, value);
    endtask

    // Writes all four registers back to back; only called while idle.
    task automatic configure(input logic [PATTERN_W-1:0] pat, input logic [LENGTH_W-1:0] len,
                             input logic [COUNT_W-1:0] max_count,
                             input logic [LIMIT_W-1:0] lim);
        write_reg(REG_PATTERN, pat);
        write_reg(REG_LENGTH, PATTERN_W'(len));
        write_reg(REG_MAX_MATCHES, PATTERN_W'(max_count));
        write_reg(REG_SEARCH_LIMIT, PATTERN_W'(lim));
        i_cfg_we <= 1'b0;
    endtask

    // A region is mostly copies of the active pattern, some with one bit
    // flipped, mixed with single pattern bytes and fully random bytes. The
    // copies land back to back at random, which exercises the rule that the
    // next match must leave a gap of at least one byte after the last one.
    // Without a restart the region just continues the previous stream.
    task automatic send_region(input int count, input bit restart);
        int          sent;
        int          len;
        int          bad;
        int          lane;
        logic [7:0]  b;
        sent = 0;
        len  = match_model.active_length();
        while (sent < count) begin
            case ($urandom_range(3))
                0, 1: begin
                    bad = ($urandom_range(4) == 0) ? int'($urandom_range(len - 1)) : -1;
                    for (int j = 0; j < len; j++) begin
                        b = match_model.cfg.pattern[8 * j +: 8];
                        if (j == bad) b = b ^ (8'd1 << $urandom_range(7));
                        send_byte(b, restart && sent == 0);
                        sent++;
                    end
                end
                2: begin
                    lane = $urandom_range(7);
                    send_byte(match_model.cfg.pattern[8 * lane +: 8], restart && sent == 0);
                    sent++;
                end
                default: begin
                    send_byte(8'($urandom), restart && sent == 0);
                    sent++;
                end
            endcase
        end
    endtask

    task automatic run_phase(input logic [PATTERN_W-1:0] pat, input logic [LENGTH_W-1:0] len,
                             input logic [COUNT_W-1:0] max_count,
                             input logic [LIMIT_W-1:0] lim, input int regions);
        configure(pat, len, max_count, lim);
        repeat (regions) send_region($urandom_range(12, 1), $urandom_range(9) != 0);
        settle();
    endtask

    initial begin
        logic [PATTERN_W-1:0] pat;
        logic [LENGTH_W-1:0]  len;
        logic [COUNT_W-1:0]   max_count;
        logic [LIMIT_W-1:0]   lim;

        match_model = new();
        idle_enable        <= 1'b1;
        i_rst_n            <= 1'b0;
        i_cfg_we           <= 1'b0;
        i_cfg_index        <= REG_PATTERN;
        i_cfg_data         <= '0;
        byte_ch.valid      <= 1'b0;
        byte_ch.code_byte  <= 8'h00;
        byte_ch.first_byte <= 1'b0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Reset configuration: an all-zero pattern of eight bytes. Without a
        // first-byte flag the stream starts at offset zero, nothing may match
        // before eight bytes are in, the eighth byte gives the single match
        // the default count allows, and the ninth is ignored.
        for (int i = 0; i < 9; i++) send_byte(8'h00, 1'b0);
        settle();

        // Length zero behaves as one byte. In a run of equal bytes the skip
        // rule lets only every other byte start a match; the third match
        // ends the search and the last byte is ignored.
        configure(64'hFF, 4'd0, 8'd3, 16'hFFFF);
        for (int i = 0; i < 6; i++) send_byte((i == 3) ? 8'h00 : 8'hFF, i == 0);
        settle();

        // A length above the window width is cut to eight bytes; the
        // smallest nonzero search limit still admits a match at offset zero.
        configure(64'h8877_6655_4433_2211, 4'd15, 8'd2, 16'd1);
        for (int i = 0; i < 8; i++) send_byte(8'(8'h11 * (i + 1)), i == 0);
        settle();

        // Extremes of the registers: all-ones pattern at full length with
        // the largest count and limit, then a zero limit where nothing may
        // ever match.
        run_phase('1, 4'd8, 8'd255, 16'hFFFF, 4);
        run_phase('0, 4'd1, 8'd1, 16'd0, 2);

        // A count of zero keeps searching until the match counter saturates
        // at 255; that match carries the done flag and the rest is ignored.
        // This stretch runs with no idling on either side.
        idle_enable <= 1'b0;
        configure(64'h0123_4567_89AB_CDAB, 4'd1, 8'd0, 16'hFFFF);
        for (int i = 0; i < SATURATION_BYTES; i++) send_byte(8'hAB, i == 0);
        settle();
        idle_enable <= 1'b1;

        // Random settings. Lengths of zero or past the window, a count of
        // zero, and small or zero limits all come up now and then.
        for (int k = 0; k < RANDOM_PHASES; k++) begin
            pat = ($urandom_range(2) == 0) ? {8{8'($urandom)}} : {$urandom, $urandom};
            if ($urandom_range(4) == 0) begin
                len = ($urandom_range(1) == 0) ? 4'd0 : 4'($urandom_range(15, 9));
            end else begin
                len = 4'($urandom_range(8, 1));
            end
            max_count = ($urandom_range(5) == 0) ? 8'd0 : 8'($urandom_range(6, 1));
            case ($urandom_range(2))
                0:       lim = 16'($urandom_range(40));
                1:       lim = 16'hFFFF;
                default: lim = 16'($urandom);
            endcase
            run_phase(pat, len, max_count, lim, $urandom_range(3, 2));
        end

        // A final random phase, then the verdict.
        run_phase({$urandom, $urandom}, 4'($urandom_range(8, 1)), 8'($urandom_range(6, 1)),
                  16'hFFFF, 3);

        if (match_model.mismatch_count == 0 && match_model.pending_matches.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
